// ----- hdl/ibmcv_pkg.sv -----
// Package for the IBM hexadecimal / IEEE single float converter.
// Holds direction codes and a leading-one helper; no dependencies.
package ibmcv_pkg;

    typedef enum logic {
        DIR_IBM_TO_IEEE = 1'b0,
        DIR_IEEE_TO_IBM = 1'b1
    } t_dir;

    // position of the highest set bit of a 24-bit value (0 when empty)
    function automatic logic [4:0] top_bit24(input logic [23:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

endpackage

// ----- hdl/ibmcv_core.sv -----
// Combinational conversion of one word in either direction.
// Depends on ibmcv_pkg.
module ibmcv_core
    import ibmcv_pkg::*;
(
    input  logic        i_dir,
    input  logic [31:0] i_word,
    output logic [31:0] o_word,
    output logic        o_ovf
);

    logic        sgn;
    logic [6:0]  ie;
    logic [23:0] f;
    logic [4:0]  p;
    logic signed [10:0] biased;
    logic signed [9:0]  r;
    logic [22:0] mant;
    logic [23:0] q;
    logic [63:0] rmask;
    logic [63:0] rem;
    logic [63:0] half;
    logic [7:0]  ex;
    logic [22:0] m;
    logic [23:0] mag;
    logic signed [9:0] pow2;
    logic signed [9:0] b;
    logic signed [9:0] fl;
    logic signed [9:0] t;
    logic [23:0] frac;
    logic [6:0]  oexp;

    always_comb begin
        sgn    = i_word[31];
        ie     = i_word[30:24];
        f      = i_word[23:0];
        p      = top_bit24(f);
        biased = 11'(signed'({6'd0, p})) + 11'(signed'({2'd0, ie, 2'b00})) - 11'sd153;
        mant   = 23'((f << (5'd23 - p)));
        r      = 10'sd131 - 10'(signed'({1'b0, ie, 2'b00}));
        rmask  = 64'd0;
        rem    = 64'd0;
        half   = 64'd0;
        q      = 24'd0;
        if (r <= 10'sd0) begin
            q = 24'(f << (-r));
        end else if (r <= 10'sd40) begin
            rmask = (64'd1 << r[5:0]) - 64'd1;
            rem   = {40'd0, f} & rmask;
            half  = 64'd1 << (r[5:0] - 6'd1);
            q     = 24'({40'd0, f} >> r[5:0]);
            if (rem > half || (rem == half && q[0])) begin
                q = q + 24'd1;
            end
        end

        ex   = i_word[30:23];
        m    = i_word[22:0];
        if (ex == 8'd0) begin
            mag  = {1'b0, m};
            pow2 = -10'sd149;
        end else begin
            mag  = {1'b1, m};
            pow2 = 10'(signed'({2'd0, ex})) - 10'sd150;
        end
        b    = 10'(signed'({5'd0, top_bit24(mag)})) + pow2;
        fl   = ((b + 10'sd200) >>> 2) - 10'sd50;
        t    = pow2 + 10'sd20 - (fl <<< 2);
        if (t >= 10'sd0) begin
            frac = mag << t;
        end else begin
            frac = mag >> (-t);
        end
        oexp = 7'(fl + 10'sd65);

        o_ovf  = 1'b0;
        o_word = 32'd0;
        if (i_dir == DIR_IBM_TO_IEEE) begin
            if (f == 24'd0) begin
                o_word = {sgn, 31'd0};
            end else if (biased >= 11'sd255) begin
                o_word = {sgn, 8'hff, 23'd0};
                o_ovf  = 1'b1;
            end else if (biased >= 11'sd1) begin
                o_word = {sgn, biased[7:0], mant};
            end else begin
                o_word = {sgn, 7'd0, q};
            end
        end else begin
            if (ex == 8'hff) begin
                if (m == 23'd0) begin
                    o_word = {sgn, 31'h7fffffff};
                    o_ovf  = 1'b1;
                end
            end else if (!(ex == 8'd0 && m == 23'd0)) begin
                o_word = {sgn, oexp, frac};
            end
        end
    end

endmodule

// ----- hdl/ibm_ieee_single_float_convert.sv -----
// Top level of the IBM hexadecimal / IEEE single float converter.
// Depends on ibmcv_pkg and ibmcv_core.
// One word per clock: a transfer taken on start is registered in r_word, then its result in r_res,
// and shown for exactly one cycle with o_done; busy is always low and the receiver cannot stall.
module ibm_ieee_single_float_convert
    import ibmcv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [31:0] i_word_in,
    output logic        o_done,
    output logic [31:0] o_word_out,
    output logic        o_overflow
);

    logic        r_v_in;
    logic        r_dir;
    logic [31:0] r_word;
    logic        r_v_out;
    logic [31:0] r_res;
    logic        r_ovf;
    logic [31:0] n_res;
    logic        n_ovf;

    assign busy = 1'b0;

    ibmcv_core u_core (
        .i_dir  (r_dir),
        .i_word (r_word),
        .o_word (n_res),
        .o_ovf  (n_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in  <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            r_v_in  <= start && !busy;
            r_v_out <= r_v_in;
        end
        r_dir  <= i_req_type;
        r_word <= i_word_in;
        r_res  <= n_res;
        r_ovf  <= n_ovf;
    end

    assign o_done     = r_v_out;
    assign o_word_out = r_res;
    assign o_overflow = r_ovf;

    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_in |=> r_v_out) else $error("lost transfer");
    a_ovf_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v_out && r_ovf) |-> (r_res[30:0] == 31'h7f800000 || r_res[30:0] == 31'h7fffffff))
        else $error("overflow without saturated word");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_v_in) else $error("start dropped");

endmodule

// ----- verif/tb.sv -----
// Testbench for ibm_ieee_single_float_convert; depends on ibmcv_pkg. Directed table and
// random words, both directions, checked against table values or an in-bench converter.
module tb;
    import ibmcv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    typedef struct {
        t_dir        dir;
        logic [31:0] word;
        logic        has_exp;
        logic [31:0] exp_word;
        logic        exp_ovf;
    } t_row;

    typedef struct {
        logic [31:0] word;
        logic        ovf;
    } t_conv;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_req_type;
    logic [31:0] i_word_in;
    logic        o_done;
    logic [31:0] o_word_out;
    logic        o_overflow;

    t_conv pending[$];
    int    n_bad;
    int    cycles;

    ibm_ieee_single_float_convert uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_word_in(i_word_in), .o_done(o_done),
        .o_word_out(o_word_out), .o_overflow(o_overflow)
    );

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int msb_pos(input logic [31:0] v);
        int p;
        p = -1;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                p = i;
            end
        end
        return p;
    endfunction

    function automatic t_conv ibm_to_ieee(input logic [31:0] w);
        t_conv       c;
        logic [31:0] sgn;
        int          e, p, biased, r;
        logic [63:0] f, q, rem, half;
        sgn = w & 32'h8000_0000;
        e = int'(w[30:24]);
        f = 64'(w[23:0]);
        c.ovf = 1'b0;
        if (f == 0) begin
            c.word = sgn;
            return c;
        end
        p = msb_pos(w[23:0]);
        biased = p + 4 * e - 280 + 127;
        if (biased >= 255) begin
            c.word = sgn | 32'h7f80_0000;
            c.ovf = 1'b1;
        end else if (biased >= 1) begin
            c.word = sgn | (32'(biased) << 23) | ((32'(f) << (23 - p)) & 32'h007f_ffff);
        end else begin
            r = 131 - 4 * e;
            if (r <= 0) begin
                q = f << (-r);
            end else if (r > 40) begin
                q = 0;
            end else begin
                rem = f & ((64'd1 << r) - 1);
                half = 64'd1 << (r - 1);
                q = f >> r;
                if (rem > half || (rem == half && q[0])) begin
                    q = q + 1;
                end
            end
            c.word = sgn | (32'(q) & 32'h00ff_ffff);
        end
        return c;
    endfunction

    function automatic t_conv ieee_to_ibm(input logic [31:0] w);
        t_conv       c;
        logic [31:0] sgn, mag, frac;
        int          ex, pow2, b, fl, t;
        sgn = w & 32'h8000_0000;
        ex = int'(w[30:23]);
        c.ovf = 1'b0;
        c.word = 32'd0;
        if (ex == 255) begin
            if (w[22:0] == 0) begin
                c.word = sgn | 32'h7fff_ffff;
                c.ovf = 1'b1;
            end
            return c;
        end
        if (ex == 0 && w[22:0] == 0) begin
            return c;
        end
        if (ex == 0) begin
            mag = 32'(w[22:0]);
            pow2 = -149;
        end else begin
            mag = 32'(w[22:0]) | 32'h0080_0000;
            pow2 = ex - 150;
        end
        b = msb_pos(mag) + pow2;
        fl = (b + 200) / 4 - 50;
        t = pow2 + 20 - 4 * fl;
        frac = (t >= 0) ? (mag << t) : (mag >> (-t));
        c.word = sgn | (32'((fl + 65) & 8'h7f) << 24) | (frac & 32'h00ff_ffff);
        return c;
    endfunction

    function automatic t_conv convert_word(input t_dir d, input logic [31:0] w);
        return (d == DIR_IBM_TO_IEEE) ? ibm_to_ieee(w) : ieee_to_ibm(w);
    endfunction

    task automatic send_word(input t_row row);
        t_conv c;
        int    gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= row.dir;
        i_word_in  <= row.word;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        c = convert_word(row.dir, row.word);
        if (row.has_exp) begin
            if (c.word !== row.exp_word || c.ovf !== row.exp_ovf) begin
                $display("table row %h/%h: predictor disagrees", row.dir, row.word);
                n_bad++;
            end
            c.word = row.exp_word;
            c.ovf = row.exp_ovf;
        end
        pending.push_back(c);
    endtask

    always @(posedge i_clk) begin
        t_conv e;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected transfer %h", o_word_out);
            end else begin
                e = pending.pop_front();
                if (o_word_out !== e.word || o_overflow !== e.ovf) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("mismatch exp %h/%b got %h/%b", e.word, e.ovf,
                                 o_word_out, o_overflow);
                    end
                end
            end
        end
    end

    function automatic t_row mk(input t_dir d, input logic [31:0] w, input logic h,
                                input logic [31:0] ew, input logic eo);
        t_row r;
        r.dir = d; r.word = w; r.has_exp = h; r.exp_word = ew; r.exp_ovf = eo;
        return r;
    endfunction

    initial begin
        t_row        dtab[$];
        t_row        row;
        logic [31:0] w;
        int          k;
        n_bad = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = 1'b0;
        i_word_in = 32'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        dtab.push_back(mk(DIR_IBM_TO_IEEE, 32'h0000_0000, 1, 32'h0000_0000, 0));
        dtab.push_back(mk(DIR_IBM_TO_IEEE, 32'h8000_0000, 1, 32'h8000_0000, 0));
        dtab.push_back(mk(DIR_IBM_TO_IEEE, 32'h7fff_ffff, 1, 32'h7f80_0000, 1));
        dtab.push_back(mk(DIR_IBM_TO_IEEE, 32'hffff_ffff, 1, 32'hff80_0000, 1));
        dtab.push_back(mk(DIR_IBM_TO_IEEE, 32'h4110_0000, 1, 32'h3f80_0000, 0));
        dtab.push_back(mk(DIR_IBM_TO_IEEE, 32'h0010_0000, 0, 0, 0));
        dtab.push_back(mk(DIR_IBM_TO_IEEE, 32'h00ff_ffff, 0, 0, 0));
        dtab.push_back(mk(DIR_IBM_TO_IEEE, 32'h2180_0000, 0, 0, 0));
        dtab.push_back(mk(DIR_IBM_TO_IEEE, 32'h22ff_ffff, 0, 0, 0));
        dtab.push_back(mk(DIR_IBM_TO_IEEE, 32'h1d18_0000, 0, 0, 0));
        dtab.push_back(mk(DIR_IBM_TO_IEEE, 32'h6100_0001, 0, 0, 0));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'h0000_0000, 1, 32'h0000_0000, 0));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'h8000_0000, 1, 32'h0000_0000, 0));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'h7fc0_0000, 1, 32'h0000_0000, 0));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'hffff_ffff, 1, 32'h0000_0000, 0));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'h7f80_0000, 1, 32'h7fff_ffff, 1));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'hff80_0000, 1, 32'hffff_ffff, 1));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'h3f80_0000, 1, 32'h4110_0000, 0));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'h4180_0000, 1, 32'h4210_0000, 0));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'h0000_0001, 0, 0, 0));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'h807f_ffff, 0, 0, 0));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'h7f7f_ffff, 0, 0, 0));
        dtab.push_back(mk(DIR_IEEE_TO_IBM, 32'h0080_0000, 0, 0, 0));
        foreach (dtab[i]) send_word(dtab[i]);
        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        for (int n = 0; n < 400; n++) begin
            w = $urandom;
            k = $urandom_range(0, 7);
            row.dir = t_dir'($urandom_range(0, 1));
            if (k == 0) begin
                w[30:24] = 7'($urandom_range(0, 40));
                w[30:23] = (row.dir == DIR_IEEE_TO_IBM) ? 8'($urandom_range(0, 1)) * 8'hff
                                                        : w[30:23];
            end else if (k == 1) begin
                w[23:0] = 24'h1 << $urandom_range(0, 23);
            end else if (k == 2) begin
                w[30:24] = 7'($urandom_range(90, 127));
            end
            row.word = w;
            row.has_exp = 1'b0;
            row.exp_word = 32'd0;
            row.exp_ovf = 1'b0;
            send_word(row);
        end
        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
